// ===== hw/rtl/vaar_pkg.sv =====
// Package for the axis-angle vector rotator: register index, reset value,
// fixed Q30 and Q32 constants, series divisors and the rounding shift helper.
// No dependencies.
package vaar_pkg;

  localparam logic [0:0]  REG_ZERO_EPS = 1'b0;
  localparam logic [15:0] ZERO_EPS_RST = 16'd1;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [60:0] Q30_HALF    = 61'h2000_0000;
  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;

  // Horner divisors, sine to x^9 and cosine to x^10
  localparam int unsigned SDIV [4] = '{72, 42, 20, 6};
  localparam int unsigned CDIV [5] = '{90, 56, 30, 12, 2};

  typedef struct packed {
    logic [2:0][31:0] rot;
    logic             az;
  } res_t;

  // shift right by n, round half away from zero
  function automatic logic signed [79:0] rsr(input logic signed [79:0] x,
                                             input int unsigned n);
    logic [79:0] h;
    logic [79:0] m;
    h = 80'd1 << (n - 1);
    if (x[79]) begin
      m = 80'(-x);
      m = (m + h) >> n;
      rsr = -$signed(m);
    end else begin
      m = 80'(x);
      m = (m + h) >> n;
      rsr = $signed(m);
    end
  endfunction

endpackage

// ===== hw/rtl/vector_axis_angle_rotate.sv =====
// Rodrigues rotation of a Q-format 3-D vector about an arbitrary axis.
// Throughput: one beat per cycle while the skid register is empty; the
// 32-step square root and the FRAC_BITS+1-step dividers are fully
// pipelined, one step per stage.
// Reset: all stage valids and the output/skid valid flags clear, zero_epsilon = 1.
// Depends on vaar_pkg.
module vector_axis_angle_rotate #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg (32 bits each)
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rot_x, rot_y, rot_z (32 bits each)
  output logic [95:0]  m_axis_tdata,
  // axis_zero
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int F  = FRAC_BITS;
  localparam int AW = 36;
  localparam int UW = F + 7;
  localparam int NW = 33 + F;
  localparam int NR = 36;

  localparam logic [63:0]   FULL64  = 64'd360 << F;
  localparam logic [AW-1:0] FULL    = AW'(FULL64);
  localparam logic [AW-1:0] QUARTER = AW'(64'd90 << F);
  localparam logic [AW-1:0] HALFQ   = AW'(64'd45 << F);
  localparam logic [AW-1:0] CADD    =
    AW'((((64'd1 << 31) + FULL64 - 64'd1) / FULL64) * FULL64);
  localparam int QB = 37 - $clog2(FULL64);

  localparam int B_ISQ = 5;
  localparam int B_DIV = B_ISQ + 32;
  localparam int B_DST = B_DIV + 1;
  localparam int B_K   = B_DST + F + 1;
  localparam int B_TRG = B_K + 1;
  localparam int B_HRN = B_TRG + 4;
  localparam int B_S0  = B_HRN + 15;
  localparam int B_SC  = B_S0 + 1;
  localparam int B_ROT = B_SC + 1;
  localparam int NST   = B_ROT + 7;

  typedef struct packed {
    logic [2:0][31:0]   v;
    logic [2:0][31:0]   a;
    logic [AW-1:0]      ang;
    logic [2:0][63:0]   sq;
    logic [63:0]        rem;
    logic [63:0]        res;
    logic [4:0]         sh;
    logic               sz;
    logic [2:0]         asg;
    logic [2:0][31:0]   m;
    logic [31:0]        r;
    logic [2:0][NW-1:0] dr;
    logic [2:0][F:0]    kq;
    logic [2:0][F+1:0]  k;
    logic               az;
    logic [1:0]         quad;
    logic               swp;
    logic [UW-1:0]      u;
    logic [29:0]        x;
    logic [29:0]        x2;
    logic [30:0]        ps;
    logic [30:0]        pc;
    logic [59:0]        sprod;
    logic [59:0]        cprod;
    logic [29:0]        sp;
    logic [29:0]        cp;
    logic [59:0]        spr;
    logic [59:0]        cpr;
    logic [30:0]        s0;
    logic [31:0]        sn;
    logic [31:0]        cs;
    logic [2:0][63:0]   pv;
    logic [2:0][63:0]   px1;
    logic [2:0][63:0]   px2;
    logic [2:0][63:0]   pd;
    logic [2:0][NR-1:0] t1;
    logic [2:0][NR-1:0] cr;
    logic [NR-1:0]      d;
    logic [2:0][67:0]   t2p;
    logic [68:0]        ep;
    logic [2:0][NR-1:0] t2;
    logic [NR-1:0]      e;
    logic [2:0][63:0]   t3p;
    logic [2:0][37:0]   sum;
    logic [2:0][31:0]   rot;
  } pipe_t;

  pipe_t            st_q [NST];
  pipe_t            st_d [NST];
  logic [NST-1:0]   vld_q;
  logic             en;
  logic [15:0]      eps_q;
  vaar_pkg::res_t   out_q, skid_q, fin;
  logic             out_vld_q, skid_vld_q;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == vaar_pkg::REG_ZERO_EPS) ? {16'd0, eps_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= vaar_pkg::ZERO_EPS_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2:2] == vaar_pkg::REG_ZERO_EPS) begin
      eps_q <= pwdata[15:0];
    end
  end

  // ---------------- pipeline control ----------------
  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st_d;
    end
  end

  // ---------------- front end ----------------
  always_comb begin
    st_d[0]      = st_q[0];
    st_d[0].v[0] = s_axis_tdata[31:0];
    st_d[0].v[1] = s_axis_tdata[63:32];
    st_d[0].v[2] = s_axis_tdata[95:64];
    st_d[0].a[0] = s_axis_tdata[127:96];
    st_d[0].a[1] = s_axis_tdata[159:128];
    st_d[0].a[2] = s_axis_tdata[191:160];
    st_d[0].ang  = {{(AW-32){s_axis_tdata[223]}}, s_axis_tdata[223:192]};
  end

  always_comb begin
    st_d[1] = st_q[0];
    for (int i = 0; i < 3; i++) begin
      st_d[1].sq[i] = $signed(st_q[0].a[i]) * $signed(st_q[0].a[i]);
      st_d[1].asg[i] = st_q[0].a[i][31];
      st_d[1].m[i] = st_q[0].a[i][31] ? 32'(-st_q[0].a[i]) : st_q[0].a[i];
    end
    st_d[1].ang = st_q[0].ang + CADD;
  end

  always_comb begin
    st_d[2]     = st_q[1];
    st_d[2].rem = st_q[1].sq[0] + st_q[1].sq[1] + st_q[1].sq[2];
  end

  // normalize: even shift so the sum of squares lands in [2^62, 2^64)
  always_comb begin
    logic [63:0] tt;
    logic [4:0]  ss;
    st_d[3] = st_q[2];
    tt = st_q[2].rem;
    ss = '0;
    for (int w = 4; w >= 0; w--) begin
      if (tt < (64'd1 << (64 - (2 << w)))) begin
        tt = tt << (2 << w);
        ss = ss | 5'(1 << w);
      end
    end
    st_d[3].rem = tt;
    st_d[3].sh  = ss;
    st_d[3].sz  = (st_q[2].rem == 64'd0);
  end

  always_comb begin
    logic [62:0] ms;
    st_d[4]     = st_q[3];
    st_d[4].res = '0;
    for (int i = 0; i < 3; i++) begin
      ms = 63'(st_q[3].m[i]) << st_q[3].sh;
      st_d[4].m[i] = ms[31:0];
    end
  end

  // ---------------- square root, angle reduction alongside ----------------
  for (genvar j = 0; j < 32; j++) begin : g_isq
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [AW-1:0] fs;
    if (j < QB) begin : g_mod
      assign fs = FULL << (QB - 1 - j);
    end else begin : g_nomod
      assign fs = '1;
    end
    always_comb begin
      logic [63:0] rb;
      st_d[B_ISQ+j] = st_q[B_ISQ+j-1];
      rb = st_q[B_ISQ+j-1].res + BIT;
      if (st_q[B_ISQ+j-1].rem >= rb) begin
        st_d[B_ISQ+j].rem = st_q[B_ISQ+j-1].rem - rb;
        st_d[B_ISQ+j].res = (st_q[B_ISQ+j-1].res >> 1) + BIT;
      end else begin
        st_d[B_ISQ+j].res = st_q[B_ISQ+j-1].res >> 1;
      end
      if (j < QB && st_q[B_ISQ+j-1].ang >= fs) begin
        st_d[B_ISQ+j].ang = st_q[B_ISQ+j-1].ang - fs;
      end
    end
  end

  // ---------------- axis normalization divide ----------------
  always_comb begin
    st_d[B_DIV]    = st_q[B_DIV-1];
    st_d[B_DIV].r  = st_q[B_DIV-1].res[31:0];
    st_d[B_DIV].kq = '0;
    for (int i = 0; i < 3; i++) begin
      st_d[B_DIV].dr[i] = NW'({st_q[B_DIV-1].m[i], {F{1'b0}}}) +
                          NW'(st_q[B_DIV-1].res[31:1]);
    end
  end

  for (genvar j = 0; j <= F; j++) begin : g_div
    localparam int B = F - j;
    always_comb begin
      logic [NW-1:0] rs;
      st_d[B_DST+j] = st_q[B_DST+j-1];
      rs = NW'(st_q[B_DST+j-1].r) << B;
      for (int i = 0; i < 3; i++) begin
        if (st_q[B_DST+j-1].dr[i] >= rs) begin
          st_d[B_DST+j].dr[i]    = st_q[B_DST+j-1].dr[i] - rs;
          st_d[B_DST+j].kq[i][B] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [F:0] mag;
    st_d[B_K]    = st_q[B_K-1];
    st_d[B_K].az = 1'b1;
    for (int i = 0; i < 3; i++) begin
      mag = st_q[B_K-1].sz ? '0 : st_q[B_K-1].kq[i];
      st_d[B_K].k[i] = st_q[B_K-1].asg[i] ? -(F+2)'(mag) : (F+2)'(mag);
      if (32'(mag) >= 32'(eps_q)) begin
        st_d[B_K].az = 1'b0;
      end
    end
  end

  // ---------------- sine and cosine ----------------
  always_comb begin
    logic [AW-1:0] t;
    st_d[B_TRG] = st_q[B_TRG-1];
    t = st_q[B_TRG-1].ang;
    priority if (t >= 3 * QUARTER) begin
      st_d[B_TRG].quad = 2'd3;
      st_d[B_TRG].u    = UW'(t - 3 * QUARTER);
    end else if (t >= 2 * QUARTER) begin
      st_d[B_TRG].quad = 2'd2;
      st_d[B_TRG].u    = UW'(t - 2 * QUARTER);
    end else if (t >= QUARTER) begin
      st_d[B_TRG].quad = 2'd1;
      st_d[B_TRG].u    = UW'(t - QUARTER);
    end else begin
      st_d[B_TRG].quad = 2'd0;
      st_d[B_TRG].u    = UW'(t);
    end
  end

  always_comb begin
    st_d[B_TRG+1]     = st_q[B_TRG];
    st_d[B_TRG+1].swp = (AW'(st_q[B_TRG].u) > HALFQ);
    if (AW'(st_q[B_TRG].u) > HALFQ) begin
      st_d[B_TRG+1].u = UW'(QUARTER) - st_q[B_TRG].u;
    end
  end

  always_comb begin
    logic [UW+26:0] xp;
    st_d[B_TRG+2]   = st_q[B_TRG+1];
    xp              = st_q[B_TRG+1].u * vaar_pkg::DEG2RAD_Q32;
    st_d[B_TRG+2].x = 30'(xp >> (F + 2));
  end

  always_comb begin
    logic [60:0] xx;
    st_d[B_TRG+3]    = st_q[B_TRG+2];
    xx               = st_q[B_TRG+2].x * st_q[B_TRG+2].x + vaar_pkg::Q30_HALF;
    st_d[B_TRG+3].x2 = 30'(xx >> 30);
    st_d[B_TRG+3].ps = vaar_pkg::Q30_ONE;
    st_d[B_TRG+3].pc = vaar_pkg::Q30_ONE;
  end

  for (genvar i = 0; i < 5; i++) begin : g_hrn
    localparam int          BA = B_HRN + 3 * i;
    localparam logic [6:0]  SD = 7'((i < 4) ? vaar_pkg::SDIV[(i < 4) ? i : 0] : 1);
    localparam logic [6:0]  CD = 7'(vaar_pkg::CDIV[i]);
    localparam logic [29:0] SR = 30'((64'd1 << 30) / SD);
    localparam logic [29:0] CR = 30'((64'd1 << 30) / CD);

    always_comb begin
      st_d[BA]       = st_q[BA-1];
      st_d[BA].cprod = st_q[BA-1].x2 * st_q[BA-1].pc;
      if (i < 4) begin
        st_d[BA].sprod = st_q[BA-1].x2 * st_q[BA-1].ps;
      end
    end

    always_comb begin
      logic [60:0] sr, cr;
      st_d[BA+1]     = st_q[BA];
      cr             = st_q[BA].cprod + vaar_pkg::Q30_HALF;
      st_d[BA+1].cp  = 30'(cr >> 30);
      st_d[BA+1].cpr = 30'(cr >> 30) * CR;
      if (i < 4) begin
        sr             = st_q[BA].sprod + vaar_pkg::Q30_HALF;
        st_d[BA+1].sp  = 30'(sr >> 30);
        st_d[BA+1].spr = 30'(sr >> 30) * SR;
      end
    end

    always_comb begin
      logic [29:0] sq0, cq0;
      logic [36:0] sqd, cqd;
      st_d[BA+2] = st_q[BA+1];
      cq0 = 30'(st_q[BA+1].cpr >> 30);
      cqd = cq0 * CD;
      if (37'(st_q[BA+1].cp) - cqd >= 37'(CD)) begin
        cq0 = cq0 + 30'd1;
      end
      st_d[BA+2].pc = vaar_pkg::Q30_ONE - 31'(cq0);
      if (i < 4) begin
        sq0 = 30'(st_q[BA+1].spr >> 30);
        sqd = sq0 * SD;
        if (37'(st_q[BA+1].sp) - sqd >= 37'(SD)) begin
          sq0 = sq0 + 30'd1;
        end
        st_d[BA+2].ps = vaar_pkg::Q30_ONE - 31'(sq0);
      end
    end
  end

  always_comb begin
    logic [61:0] sp;
    st_d[B_S0]    = st_q[B_S0-1];
    sp            = st_q[B_S0-1].x * st_q[B_S0-1].ps + 62'(vaar_pkg::Q30_HALF);
    st_d[B_S0].s0 = 31'(sp >> 30);
  end

  always_comb begin
    logic [31:0] sa, sb;
    st_d[B_SC] = st_q[B_SC-1];
    sa = {1'b0, st_q[B_SC-1].swp ? st_q[B_SC-1].pc : st_q[B_SC-1].s0};
    sb = {1'b0, st_q[B_SC-1].swp ? st_q[B_SC-1].s0 : st_q[B_SC-1].pc};
    unique case (st_q[B_SC-1].quad)
      2'd0: begin st_d[B_SC].sn = sa;  st_d[B_SC].cs = sb;  end
      2'd1: begin st_d[B_SC].sn = sb;  st_d[B_SC].cs = -sa; end
      2'd2: begin st_d[B_SC].sn = -sa; st_d[B_SC].cs = -sb; end
      default: begin st_d[B_SC].sn = -sb; st_d[B_SC].cs = sa; end
    endcase
  end

  // ---------------- rotation ----------------
  always_comb begin
    st_d[B_ROT] = st_q[B_ROT-1];
    for (int i = 0; i < 3; i++) begin
      st_d[B_ROT].pv[i] = $signed(st_q[B_ROT-1].v[i]) * $signed(st_q[B_ROT-1].cs);
      st_d[B_ROT].pd[i] = $signed(st_q[B_ROT-1].k[i]) * $signed(st_q[B_ROT-1].v[i]);
    end
    st_d[B_ROT].px1[0] = $signed(st_q[B_ROT-1].k[1]) * $signed(st_q[B_ROT-1].v[2]);
    st_d[B_ROT].px2[0] = $signed(st_q[B_ROT-1].k[2]) * $signed(st_q[B_ROT-1].v[1]);
    st_d[B_ROT].px1[1] = $signed(st_q[B_ROT-1].k[2]) * $signed(st_q[B_ROT-1].v[0]);
    st_d[B_ROT].px2[1] = $signed(st_q[B_ROT-1].k[0]) * $signed(st_q[B_ROT-1].v[2]);
    st_d[B_ROT].px1[2] = $signed(st_q[B_ROT-1].k[0]) * $signed(st_q[B_ROT-1].v[1]);
    st_d[B_ROT].px2[2] = $signed(st_q[B_ROT-1].k[1]) * $signed(st_q[B_ROT-1].v[0]);
  end

  always_comb begin
    logic signed [63:0] ds;
    st_d[B_ROT+1] = st_q[B_ROT];
    for (int i = 0; i < 3; i++) begin
      st_d[B_ROT+1].t1[i] = NR'(vaar_pkg::rsr($signed(st_q[B_ROT].pv[i]), 30));
      st_d[B_ROT+1].cr[i] = NR'(vaar_pkg::rsr(
        $signed(st_q[B_ROT].px1[i]) - $signed(st_q[B_ROT].px2[i]), F));
    end
    ds = $signed(st_q[B_ROT].pd[0]) + $signed(st_q[B_ROT].pd[1]) +
         $signed(st_q[B_ROT].pd[2]);
    st_d[B_ROT+1].d = NR'(vaar_pkg::rsr(ds, F));
  end

  always_comb begin
    logic signed [32:0] ocs;
    st_d[B_ROT+2] = st_q[B_ROT+1];
    ocs = $signed({2'b00, vaar_pkg::Q30_ONE}) - $signed(st_q[B_ROT+1].cs);
    for (int i = 0; i < 3; i++) begin
      st_d[B_ROT+2].t2p[i] = $signed(st_q[B_ROT+1].cr[i]) * $signed(st_q[B_ROT+1].sn);
    end
    st_d[B_ROT+2].ep = $signed(st_q[B_ROT+1].d) * ocs;
  end

  always_comb begin
    st_d[B_ROT+3] = st_q[B_ROT+2];
    for (int i = 0; i < 3; i++) begin
      st_d[B_ROT+3].t2[i] = NR'(vaar_pkg::rsr($signed(st_q[B_ROT+2].t2p[i]), 30));
    end
    st_d[B_ROT+3].e = NR'(vaar_pkg::rsr($signed(st_q[B_ROT+2].ep), 30));
  end

  always_comb begin
    st_d[B_ROT+4] = st_q[B_ROT+3];
    for (int i = 0; i < 3; i++) begin
      st_d[B_ROT+4].t3p[i] = $signed(st_q[B_ROT+3].k[i]) * $signed(st_q[B_ROT+3].e);
    end
  end

  always_comb begin
    st_d[B_ROT+5] = st_q[B_ROT+4];
    for (int i = 0; i < 3; i++) begin
      st_d[B_ROT+5].sum[i] = $signed(st_q[B_ROT+4].t1[i]) +
                             $signed(st_q[B_ROT+4].t2[i]) +
                             $signed(38'(vaar_pkg::rsr($signed(st_q[B_ROT+4].t3p[i]), F)));
    end
  end

  always_comb begin
    logic [37:0] s;
    st_d[B_ROT+6] = st_q[B_ROT+5];
    for (int i = 0; i < 3; i++) begin
      s = st_q[B_ROT+5].sum[i];
      if (st_q[B_ROT+5].az) begin
        st_d[B_ROT+6].rot[i] = st_q[B_ROT+5].v[i];
      end else if (s[37:31] != {7{s[37]}}) begin
        st_d[B_ROT+6].rot[i] = s[37] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        st_d[B_ROT+6].rot[i] = s[31:0];
      end
    end
  end

  // ---------------- output register and skid ----------------
  assign fin.rot = st_q[NST-1].rot;
  assign fin.az  = st_q[NST-1].az;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= vld_q[NST-1];
      end
    end else if (en && vld_q[NST-1]) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) begin
      out_q <= skid_vld_q ? skid_q : fin;
    end else if (en) begin
      skid_q <= fin;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.rot;
  assign m_axis_tuser  = out_q.az;

endmodule
